// File: rtl/belief_measure_query_engine_top_defines.svh
// Assertion macros for the belief measure query engine.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef BELIEF_MEASURE_QUERY_ENGINE_TOP_DEFINES_SVH
`define BELIEF_MEASURE_QUERY_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define BMQE_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMQE_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bmqe_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the belief measure query engine.
// No dependencies.
package bmqe_pkg;

    localparam int Q15_W     = 16;
    localparam int CARD_W    = 6;   // cardinality of a set over up to 32 hypotheses
    localparam int X_W       = 21;  // mass * card, max 32768 * 32
    localparam int DIV_SHIFT = 22;
    localparam int RECIP_W   = 23;
    localparam int DRAIN_W   = 3;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 80;

    localparam logic [Q15_W-1:0]   ONE_Q15      = 16'd32768;
    localparam logic [DRAIN_W-1:0] DRAIN_CYCLES = 3'd5;  // read, stage B, three divide stages

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DRAIN,
        ST_OUT
    } state_t;

    function automatic logic [Q15_W-1:0] sat_add(input logic [Q15_W-1:0] a,
                                                 input logic [Q15_W-1:0] b);
        logic [Q15_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_Q15}) ? ONE_Q15 : s[Q15_W-1:0];
    endfunction

    // floor(2^22 / c)
    function automatic logic [RECIP_W-1:0] recip(input logic [CARD_W-1:0] c);
        logic [RECIP_W-1:0] r;
        case (c)
            6'd1:    r = 23'd4194304;
            6'd2:    r = 23'd2097152;
            6'd3:    r = 23'd1398101;
            6'd4:    r = 23'd1048576;
            6'd5:    r = 23'd838860;
            6'd6:    r = 23'd699050;
            6'd7:    r = 23'd599186;
            6'd8:    r = 23'd524288;
            6'd9:    r = 23'd466033;
            6'd10:   r = 23'd419430;
            6'd11:   r = 23'd381300;
            6'd12:   r = 23'd349525;
            6'd13:   r = 23'd322638;
            6'd14:   r = 23'd299593;
            6'd15:   r = 23'd279620;
            6'd16:   r = 23'd262144;
            6'd17:   r = 23'd246723;
            6'd18:   r = 23'd233016;
            6'd19:   r = 23'd220752;
            6'd20:   r = 23'd209715;
            6'd21:   r = 23'd199728;
            6'd22:   r = 23'd190650;
            6'd23:   r = 23'd182361;
            6'd24:   r = 23'd174762;
            6'd25:   r = 23'd167772;
            6'd26:   r = 23'd161319;
            6'd27:   r = 23'd155344;
            6'd28:   r = 23'd149796;
            6'd29:   r = 23'd144631;
            6'd30:   r = 23'd139810;
            6'd31:   r = 23'd135300;
            6'd32:   r = 23'd131072;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bmqe_focal_mem.sv
`timescale 1ns / 1ps
// Focal element store: one write port, one registered read port.
// No dependencies.
module bmqe_focal_mem #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bmqe_betp_div.sv
`timescale 1ns / 1ps
// Pignistic term unit: floor(mass * k / card), three pipelined stages.
// Depends on bmqe_pkg (reciprocal table, widths).
module bmqe_betp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [bmqe_pkg::Q15_W-1:0]    w,
    input  logic [bmqe_pkg::CARD_W-1:0]   k,
    input  logic [bmqe_pkg::CARD_W-1:0]   c,
    output logic                          out_valid,
    output logic [bmqe_pkg::Q15_W-1:0]    term
);

    localparam int X_W = bmqe_pkg::X_W;
    localparam int P_W = bmqe_pkg::X_W + bmqe_pkg::RECIP_W;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [X_W-1:0]                x1_reg, x2_reg;
    logic [bmqe_pkg::CARD_W-1:0]   c1_reg, c2_reg;
    logic [P_W-1:0]                p2_reg;
    logic [bmqe_pkg::Q15_W-1:0]    term_reg;

    logic [X_W-1:0]                prod1;
    logic [P_W-1:0]                prod2;
    logic [bmqe_pkg::Q15_W-1:0]    q_est;
    logic [X_W-1:0]                qc;
    logic [X_W-1:0]                rem;
    logic [bmqe_pkg::Q15_W-1:0]    term_next;

    assign prod1 = X_W'(w) * X_W'(k);
    assign prod2 = P_W'(x1_reg) * P_W'(bmqe_pkg::recip(c1_reg));

    // estimate is exact or one low; one compare fixes it
    assign q_est     = p2_reg[bmqe_pkg::DIV_SHIFT +: bmqe_pkg::Q15_W];
    assign qc        = X_W'(q_est) * X_W'(c2_reg);
    assign rem       = x2_reg - qc;
    assign term_next = (rem >= X_W'(c2_reg)) ? q_est + 16'd1 : q_est;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x1_reg   <= prod1;
        c1_reg   <= c;
        p2_reg   <= prod2;
        x2_reg   <= x1_reg;
        c2_reg   <= c1_reg;
        term_reg <= term_next;
    end

    assign out_valid = v3_reg;
    assign term      = term_reg;

endmodule

// File: rtl/belief_measure_query_engine_top.sv
`timescale 1ns / 1ps
// Belief measure query engine top: sequencer, entry walk, sums, result register.
// Depends on bmqe_pkg, bmqe_focal_mem, bmqe_betp_div and the defines header.
`include "belief_measure_query_engine_top_defines.svh"

// One word at a time. Clear and append pass from accept through the decode and output
// states to the result register. A query walks the stored entries one per cycle through
// the single read port of the focal store, then drains a five-stage pipeline (store read,
// compare stage, three-stage pignistic divide) before its result is loaded.
// s_tready is low while a word is in work; a finished result waits in the
// output register while the next word is taken. Table capacity is MAX_FOCALS.
module belief_measure_query_engine_top #(
    parameter int FRAME_BITS = 16,
    parameter int MAX_FOCALS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bmqe_pkg::S_DATA_W-1:0]   s_tdata,   // set_mask[15:0], mass[31:16]
    input  logic [1:0]                      s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bmqe_pkg::M_DATA_W-1:0]   m_tdata,   // mass_of_set, belief, plausibility,
                                                       // commonality, pignistic (16b each)
    output logic [0:0]                      m_tuser    // status
);

    localparam int IDX_W = (MAX_FOCALS > 1) ? $clog2(MAX_FOCALS) : 1;
    localparam int CNT_W = $clog2(MAX_FOCALS + 1);
    localparam int QW    = bmqe_pkg::Q15_W;
    localparam int CW    = bmqe_pkg::CARD_W;
    localparam int ENT_W = FRAME_BITS + QW;

    function automatic logic [CW-1:0] popcount(input logic [FRAME_BITS-1:0] v);
        logic [CW-1:0] n;
        n = '0;
        for (int i = 0; i < FRAME_BITS; i++) begin
            n = n + CW'(v[i]);
        end
        return n;
    endfunction

    bmqe_pkg::state_t state_reg, state_next;

    logic [1:0]              func_reg;
    logic [FRAME_BITS-1:0]   qset_reg;
    logic [QW-1:0]           mass_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [bmqe_pkg::DRAIN_W-1:0] drain_reg, drain_next;
    logic                    status_reg, status_next;

    logic                    s_accept;
    logic [31:0]             set_ext;
    logic                    tbl_full;
    logic                    mem_we;
    logic                    rd_en;
    logic                    acc_clr;
    logic                    out_load;
    logic [QW-1:0]           mass_sat;
    logic [ENT_W-1:0]        rd_data;
    logic                    rd_v_reg;

    logic [FRAME_BITS-1:0]   a_set;
    logic [QW-1:0]           a_w;

    logic                    b_v_reg, b_eq_reg, b_bel_reg, b_pl_reg, b_com_reg;
    logic [QW-1:0]           b_w_reg;
    logic [CW-1:0]           b_k_reg, b_ca_reg;
    logic [CW-1:0]           a_ca;

    logic                    found_reg;
    logic [QW-1:0]           mset_acc_reg, bel_acc_reg, pl_acc_reg, com_acc_reg, betp_acc_reg;

    logic                    div_v;
    logic [QW-1:0]           div_term;

    logic                    m_tvalid_reg;
    logic [bmqe_pkg::M_DATA_W-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    assign s_tready = (state_reg == bmqe_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign set_ext  = {16'd0, s_tdata[15:0]};
    assign tbl_full = (count_reg >= CNT_W'(MAX_FOCALS));
    assign mass_sat = (mass_reg > bmqe_pkg::ONE_Q15) ? bmqe_pkg::ONE_Q15 : mass_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tuser;
            qset_reg <= set_ext[FRAME_BITS-1:0];
            mass_reg <= s_tdata[31:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bmqe_pkg::ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            drain_reg  <= '0;
            status_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            drain_reg  <= drain_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        drain_next  = drain_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        acc_clr     = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            bmqe_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = bmqe_pkg::ST_DECODE;
                end
            end
            bmqe_pkg::ST_DECODE: begin
                acc_clr     = 1'b1;
                status_next = 1'b0;
                idx_next    = '0;
                drain_next  = bmqe_pkg::DRAIN_CYCLES - 3'd1;
                case (func_reg)
                    bmqe_pkg::FUNC_CLEAR: begin
                        count_next = '0;
                        state_next = bmqe_pkg::ST_OUT;
                    end
                    bmqe_pkg::FUNC_APPEND: begin
                        if (tbl_full) begin
                            status_next = 1'b1;
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = bmqe_pkg::ST_OUT;
                    end
                    bmqe_pkg::FUNC_QUERY: begin
                        state_next = (count_reg == '0) ? bmqe_pkg::ST_DRAIN
                                                       : bmqe_pkg::ST_WALK;
                    end
                    default: begin
                        state_next = bmqe_pkg::ST_OUT;
                    end
                endcase
            end
            bmqe_pkg::ST_WALK: begin
                rd_en    = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == count_reg) begin
                    state_next = bmqe_pkg::ST_DRAIN;
                end
            end
            bmqe_pkg::ST_DRAIN: begin
                if (drain_reg == '0) begin
                    state_next = bmqe_pkg::ST_OUT;
                end else begin
                    drain_next = drain_reg - 3'd1;
                end
            end
            bmqe_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = bmqe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bmqe_pkg::ST_IDLE;
            end
        endcase
    end

    bmqe_focal_mem #(
        .DEPTH  (MAX_FOCALS),
        .DATA_W (ENT_W),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({qset_reg, mass_sat}),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // stage A: set relations of the entry just read
    assign a_set = rd_data[ENT_W-1:QW];
    assign a_w   = rd_data[QW-1:0];
    assign a_ca  = popcount(a_set);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            b_v_reg  <= 1'b0;
        end else begin
            rd_v_reg <= rd_en;
            b_v_reg  <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_eq_reg  <= (a_set == qset_reg);
        b_bel_reg <= (a_set != '0) && ((a_set & ~qset_reg) == '0);
        b_pl_reg  <= ((a_set & qset_reg) != '0);
        b_com_reg <= ((qset_reg & ~a_set) == '0);
        b_w_reg   <= a_w;
        b_k_reg   <= popcount(a_set & qset_reg);
        b_ca_reg  <= a_ca;
    end

    bmqe_betp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_v_reg && (b_ca_reg != '0)),
        .w         (b_w_reg),
        .k         (b_k_reg),
        .c         (b_ca_reg),
        .out_valid (div_v),
        .term      (div_term)
    );

    // running sums, saturating at one, and the mass of the first entry equal to the query set
    always_ff @(posedge aclk) begin
        if (acc_clr) begin
            found_reg    <= 1'b0;
            mset_acc_reg <= '0;
            bel_acc_reg  <= '0;
            pl_acc_reg   <= '0;
            com_acc_reg  <= '0;
        end else if (b_v_reg) begin
            if (b_eq_reg && !found_reg) begin
                found_reg    <= 1'b1;
                mset_acc_reg <= b_w_reg;
            end
            if (b_bel_reg) begin
                bel_acc_reg <= bmqe_pkg::sat_add(bel_acc_reg, b_w_reg);
            end
            if (b_pl_reg) begin
                pl_acc_reg <= bmqe_pkg::sat_add(pl_acc_reg, b_w_reg);
            end
            if (b_com_reg) begin
                com_acc_reg <= bmqe_pkg::sat_add(com_acc_reg, b_w_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_clr) begin
            betp_acc_reg <= '0;
        end else if (div_v) begin
            betp_acc_reg <= bmqe_pkg::sat_add(betp_acc_reg, div_term);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {betp_acc_reg, com_acc_reg, pl_acc_reg, bel_acc_reg, mset_acc_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `BMQE_CHECK_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_FOCALS), "count beyond depth")
    `BMQE_CHECK_NEXT(a_full_hold, (state_reg == bmqe_pkg::ST_DECODE) && (func_reg == bmqe_pkg::FUNC_APPEND) && tbl_full, (count_reg == $past(count_reg)) && status_reg, "refused append moved table")
    `BMQE_CHECK_NOW(a_pipe_idle, state_reg == bmqe_pkg::ST_IDLE, !rd_v_reg && !b_v_reg && !div_v, "walk pipeline busy while idle")
    `BMQE_CHECK_NEXT(a_out_post, out_load, m_tvalid_reg, "result word not posted")

endmodule

// File: tb/sv/tb_belief_measure_query_engine_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for belief_measure_query_engine_top: directed and random
// clear/append/query words against an in-bench focal table model, with random idling.
// Depends on bmqe_pkg and the top level RTL.
module tb_belief_measure_query_engine_top;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam int         FOCAL_DEPTH  = 64;
    localparam int         CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic        status;
        logic [15:0] mass_of_set;
        logic [15:0] belief;
        logic [15:0] plausibility;
        logic [15:0] commonality;
        logic [15:0] pignistic;
    } measure_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // set_mask[15:0], mass[31:16]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;   // mass_of_set, belief, plausibility, commonality, pignistic
    logic [0:0]  m_tuser;   // status

    // focal table as seen by accepted words
    logic [15:0] tbl_set  [FOCAL_DEPTH];
    logic [15:0] tbl_mass [FOCAL_DEPTH];
    int          tbl_count;

    measure_t    measure_q[$];
    int          errors;
    int          sent_words;
    int          cycles;
    int          hold_len;
    bit          idle_on;

    belief_measure_query_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [15:0] clip_one(input int unsigned v);
        return (v > bmqe_pkg::ONE_Q15) ? bmqe_pkg::ONE_Q15 : v[15:0];
    endfunction

    function automatic measure_t compute_measures(input logic [1:0] f, input logic [15:0] qset,
                                                  input logic [15:0] m);
        measure_t    r;
        int unsigned bel, pl, com, pig, ca, ones;
        bit          found;
        r     = '0;
        bel   = 0;
        pl    = 0;
        com   = 0;
        pig   = 0;
        found = 1'b0;
        case (f)
            bmqe_pkg::FUNC_CLEAR: tbl_count = 0;
            bmqe_pkg::FUNC_APPEND: begin
                if (tbl_count >= FOCAL_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    tbl_set[tbl_count]  = qset;
                    tbl_mass[tbl_count] = clip_one(m);
                    tbl_count++;
                end
            end
            bmqe_pkg::FUNC_QUERY: begin
                for (int k = 0; k < tbl_count; k++) begin
                    ca   = $countones(tbl_set[k]);
                    ones = $countones(tbl_set[k] & qset);
                    if (!found && tbl_set[k] == qset) begin
                        r.mass_of_set = tbl_mass[k];
                        found = 1'b1;
                    end
                    if (ca > 0 && (tbl_set[k] & ~qset) == 16'h0000) bel += tbl_mass[k];
                    if ((tbl_set[k] & qset) != 16'h0000) pl += tbl_mass[k];
                    if ((qset & ~tbl_set[k]) == 16'h0000) com += tbl_mass[k];
                    if (ca > 0) pig += (tbl_mass[k] * ones) / ca;
                end
                r.belief       = clip_one(bel);
                r.plausibility = clip_one(pl);
                r.commonality  = clip_one(com);
                r.pignistic    = clip_one(pig);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [15:0] set_mask,
                             input logic [15:0] mass);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {mass, set_mask};
        do @(posedge aclk); while (!s_tready);
        measure_q.push_back(compute_measures(f, set_mask, mass));
        sent_words++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (measure_q.size() != 0);
    endtask

    // receiver: long hold on request, random stall bursts, else ready
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic void check_field(input string label, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        measure_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (measure_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h/%h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = measure_q.pop_front();
                check_field("status", want.status, m_tuser[0]);
                check_field("mass_of_set", want.mass_of_set, m_tdata[15:0]);
                check_field("belief", want.belief, m_tdata[31:16]);
                check_field("plausibility", want.plausibility, m_tdata[47:32]);
                check_field("commonality", want.commonality, m_tdata[63:48]);
                check_field("pignistic", want.pignistic, m_tdata[79:64]);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // mostly narrow frames so that sets overlap often
    function automatic logic [15:0] pick_set();
        int unsigned w;
        w = ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(2, 6);
        return 16'($urandom) & 16'((32'd1 << w) - 1);
    endfunction

    function automatic logic [15:0] pick_mass();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'($urandom_range(0, 4096));
        if (r < 7) return 16'($urandom_range(0, 32768));
        if (r == 7) return bmqe_pkg::ONE_Q15;
        return 16'($urandom_range(32769, 65535));
    endfunction

    function automatic logic [15:0] pick_query();
        int unsigned r;
        logic [15:0] base;
        r    = $urandom_range(0, 19);
        base = (tbl_count != 0) ? tbl_set[$urandom_range(0, tbl_count - 1)] : 16'($urandom);
        if (r < 6) return base;
        if (r < 9) return base & 16'($urandom);
        if (r < 12) return base | (16'd1 << $urandom_range(0, 15));
        if (r < 14) return 16'h0000;
        if (r == 14) return 16'hFFFF;
        return 16'($urandom) & (16'hFFFF >> $urandom_range(0, 12));
    endfunction

    task automatic run_sequences(input int n_words);
        int stop_at, kind, n_app, n_qry;
        stop_at = sent_words + n_words;
        while (sent_words < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                // noise: any func, any data
                repeat ($urandom_range(1, 4))
                    send_word(2'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                if ($urandom_range(0, 3) != 0)
                    send_word(bmqe_pkg::FUNC_CLEAR, 16'($urandom), 16'($urandom));
                // some runs overfill the table
                n_app = (kind < 27) ? FOCAL_DEPTH - tbl_count + $urandom_range(1, 4)
                                    : $urandom_range(1, 10);
                repeat (n_app) send_word(bmqe_pkg::FUNC_APPEND, pick_set(), pick_mass());
                n_qry = $urandom_range(2, 8);
                repeat (n_qry) send_word(bmqe_pkg::FUNC_QUERY, pick_query(), 16'($urandom));
            end
        end
    endtask

    task automatic test_empty_table();
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0000, 16'h0000);
        send_word(bmqe_pkg::FUNC_QUERY, 16'hFFFF, 16'hFFFF);
        send_word(FUNC_UNKNOWN, 16'hFFFF, 16'hFFFF);
        wait_all_results();
    endtask

    task automatic test_directed_ops();
        send_word(bmqe_pkg::FUNC_CLEAR, 16'h0000, 16'h0000);
        send_word(bmqe_pkg::FUNC_APPEND, 16'h0000, 16'h0100);  // empty-set entry
        send_word(bmqe_pkg::FUNC_APPEND, 16'hFFFF, 16'hFFFF);  // mass above one
        send_word(bmqe_pkg::FUNC_APPEND, 16'h0003, 16'h4000);
        send_word(bmqe_pkg::FUNC_APPEND, 16'h0001, 16'h0000);
        send_word(bmqe_pkg::FUNC_APPEND, 16'h8000, 16'h2AAA);
        send_word(bmqe_pkg::FUNC_APPEND, 16'h00F0, 16'h7FFF);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0000, 16'h0000);
        send_word(bmqe_pkg::FUNC_QUERY, 16'hFFFF, 16'h0000);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0003, 16'hFFFF);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0001, 16'h0000);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h8001, 16'h0000);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h00F5, 16'h0000);
        send_word(FUNC_UNKNOWN, 16'h5555, 16'hAAAA);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0003, 16'h0000);
        send_word(bmqe_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF);
        send_word(bmqe_pkg::FUNC_QUERY, 16'h0003, 16'h0000);
        wait_all_results();
    endtask

    task automatic test_output_hold();
        hold_len = 300;
        send_word(bmqe_pkg::FUNC_CLEAR, 16'h0000, 16'h0000);
        repeat (4) send_word(bmqe_pkg::FUNC_APPEND, pick_set(), pick_mass());
        repeat (6) send_word(bmqe_pkg::FUNC_QUERY, pick_query(), 16'h0000);
        wait_all_results();
    endtask

    task automatic test_random_sequences();
        run_sequences(790);
        wait_all_results();
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        run_sequences(40);
        wait_all_results();
    endtask

    initial begin
        errors     = 0;
        sent_words = 0;
        hold_len   = 0;
        tbl_count  = 0;
        idle_on    = 1'b1;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= bmqe_pkg::FUNC_CLEAR;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_directed_ops();
        test_output_hold();
        test_random_sequences();
        test_quiet_tail();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
